// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file eeg_checker.sv.
// Needs only the clock and reset names handed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/eeg_pkg.sv =====
// Shared types and constants for the extended Euclid GCD block.
// No dependencies.
`default_nettype none

package eeg_pkg;

   localparam int GCD_W  = 63;
   localparam int COEF_W = 64;

   typedef logic [COEF_W-1:0] coef_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== src/extended_euclid_gcd.sv =====
// Extended Euclid GCD block: usage
// Input channel req_*: operand_a and operand_b; only the low WIDTH bits count.
// Result channel rsp_*: gcd_value and the Bezout coefficients coeff_a, coeff_b
// (64-bit two's complement) with a*coeff_a + b*coeff_b = gcd.
// A beat moves when valid is high and stall is low at a rising clock edge.
// One item at a time: req_stall is high from the accepted beat until its
// result beat has been taken.
// Each item takes k Euclid divisions (up to about 92 at WIDTH 63). Each
// division checks the remainder in ST_CHECK, then runs on the shared divide /
// multiply-accumulate unit in ST_DIV, one quotient bit a cycle, and then
// updates the remainders and coefficients.
// b zero gives gcd a, coefficients 1 and 0, with no division.
// While rsp_stall is high the result beat holds and no new item is taken.
// Synchronous reset returns the block to idle; any item in flight is dropped.
// Depends on eeg_pkg and eeg_iter_unit.
`default_nettype none

module extended_euclid_gcd #(
   parameter int WIDTH = 63
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [eeg_pkg::GCD_W-1:0]         req_operand_a,
   input  wire logic [eeg_pkg::GCD_W-1:0]         req_operand_b,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [eeg_pkg::GCD_W-1:0]              rsp_gcd_value,
   output logic signed [eeg_pkg::COEF_W-1:0]      rsp_coeff_a,
   output logic signed [eeg_pkg::COEF_W-1:0]      rsp_coeff_b
);

   eeg_pkg::state_type  state_ff, state_in;
   logic [WIDTH-1:0]    rp_ff, rp_in;
   logic [WIDTH-1:0]    rc_ff, rc_in;
   eeg_pkg::coef_type   sp_ff, sp_in;
   eeg_pkg::coef_type   sc_ff, sc_in;
   eeg_pkg::coef_type   tp_ff, tp_in;
   eeg_pkg::coef_type   tc_ff, tc_in;

   logic                unit_start;
   logic                unit_done;
   logic [WIDTH-1:0]    unit_rem;
   eeg_pkg::coef_type   unit_ps;
   eeg_pkg::coef_type   unit_pt;

   eeg_iter_unit #(.WIDTH(WIDTH)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .start     (unit_start),
      .dividend  (rp_ff),
      .divisor   (rc_ff),
      .mul_s     (sc_ff),
      .mul_t     (tc_ff),
      .done      (unit_done),
      .remainder (unit_rem),
      .prod_s    (unit_ps),
      .prod_t    (unit_pt)
   );

   always_comb begin
      state_in   = state_ff;
      rp_in      = rp_ff;
      rc_in      = rc_ff;
      sp_in      = sp_ff;
      sc_in      = sc_ff;
      tp_in      = tp_ff;
      tc_in      = tc_ff;
      unit_start = 1'b0;
      unique case (state_ff)
         eeg_pkg::ST_IDLE: begin
            if (req_valid) begin
               rp_in    = req_operand_a[WIDTH-1:0];
               rc_in    = req_operand_b[WIDTH-1:0];
               sp_in    = eeg_pkg::coef_type'(1);
               sc_in    = '0;
               tp_in    = '0;
               tc_in    = eeg_pkg::coef_type'(1);
               state_in = eeg_pkg::ST_CHECK;
            end
         end
         eeg_pkg::ST_CHECK: begin
            if (rc_ff == '0) begin
               state_in = eeg_pkg::ST_OUT;
            end else begin
               unit_start = 1'b1;
               state_in   = eeg_pkg::ST_DIV;
            end
         end
         eeg_pkg::ST_DIV: begin
            if (unit_done) begin
               rp_in    = rc_ff;
               rc_in    = unit_rem;
               sp_in    = sc_ff;
               sc_in    = sp_ff - unit_ps;
               tp_in    = tc_ff;
               tc_in    = tp_ff - unit_pt;
               state_in = eeg_pkg::ST_CHECK;
            end
         end
         eeg_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = eeg_pkg::ST_IDLE;
            end
         end
         default: state_in = eeg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eeg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rp_ff <= rp_in;
      rc_ff <= rc_in;
      sp_ff <= sp_in;
      sc_ff <= sc_in;
      tp_ff <= tp_in;
      tc_ff <= tc_in;
   end

   assign req_stall     = (state_ff != eeg_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == eeg_pkg::ST_OUT);
   assign rsp_gcd_value = eeg_pkg::GCD_W'(rp_ff);
   assign rsp_coeff_a   = $signed(sp_ff);
   assign rsp_coeff_b   = $signed(tp_ff);

endmodule

`default_nettype wire

// ===== src/eeg_iter_unit.sv =====
// Shared iterative unit: restoring division, one quotient bit per cycle,
// with the quotient times both coefficients accumulated MSB first. Uses eeg_pkg.
`default_nettype none

module eeg_iter_unit #(
   parameter int WIDTH = 63
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WIDTH-1:0]  dividend,
   input  wire logic [WIDTH-1:0]  divisor,
   input  eeg_pkg::coef_type      mul_s,
   input  eeg_pkg::coef_type      mul_t,
   output logic                   done,
   output logic [WIDTH-1:0]       remainder,
   output eeg_pkg::coef_type      prod_s,
   output eeg_pkg::coef_type      prod_t
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     dvd_ff, dvd_in;
   logic [WIDTH-1:0]     dsr_ff, dsr_in;
   eeg_pkg::coef_type    ms_ff, ms_in;
   eeg_pkg::coef_type    mt_ff, mt_in;
   eeg_pkg::coef_type    ps_ff, ps_in;
   eeg_pkg::coef_type    pt_ff, pt_in;

   logic [WIDTH:0]       trial;
   logic [WIDTH:0]       diff;
   logic                 qbit;

   assign trial = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign qbit  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      dsr_in     = dsr_ff;
      ms_in      = ms_ff;
      mt_in      = mt_ff;
      ps_in      = ps_ff;
      pt_in      = pt_ff;
      if (start) begin
         running_in = 1'b1;
         count_in   = CNT_W'(WIDTH);
         rem_in     = '0;
         dvd_in     = dividend;
         dsr_in     = divisor;
         ms_in      = mul_s;
         mt_in      = mul_t;
         ps_in      = '0;
         pt_in      = '0;
      end else if (running_ff) begin
         rem_in   = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         dvd_in   = {dvd_ff[WIDTH-2:0], 1'b0};
         // product mod 2^64, Horner form over the quotient bits
         ps_in    = {ps_ff[eeg_pkg::COEF_W-2:0], 1'b0} + (qbit ? ms_ff : '0);
         pt_in    = {pt_ff[eeg_pkg::COEF_W-2:0], 1'b0} + (qbit ? mt_ff : '0);
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      ms_ff  <= ms_in;
      mt_ff  <= mt_in;
      ps_ff  <= ps_in;
      pt_ff  <= pt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign prod_s    = ps_ff;
   assign prod_t    = pt_ff;

endmodule

`default_nettype wire

// ===== src/eeg_checker.sv =====
// Port-level checker for extended_euclid_gcd, bound to the top level.
// Depends on assert_macros.svh and eeg_pkg.
`default_nettype none
`include "assert_macros.svh"

module eeg_checker #(
   parameter int WIDTH = 63
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [eeg_pkg::GCD_W-1:0]     req_operand_b,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [eeg_pkg::GCD_W-1:0]     rsp_gcd_value
);

   logic req_beat;
   logic b_zero;

   assign req_beat = req_valid && !req_stall;
   assign b_zero   = (req_operand_b[WIDTH-1:0] == '0);

   // one item in flight: busy right after an accepted beat
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, req_stall)

   // never take input while a result waits
   `ASSERT_IMPLY(a_no_req_with_rsp, clock, reset, rsp_valid, req_stall)

   // b zero needs no division: only the check state lies between the beat and the result
   `ASSERT_NEXT(a_b_zero_fast, clock, reset, req_beat && b_zero, ##1 rsp_valid)

   // stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_gcd_value))

endmodule

bind extended_euclid_gcd eeg_checker #(.WIDTH(WIDTH)) u_eeg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operand_b (req_operand_b),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_gcd_value (rsp_gcd_value)
);

`default_nettype wire
